// ===== hdl/dadsr_pkg.sv =====
// Shared types and constants of the delay/ADSR envelope level unit.
`default_nettype none

package dadsr_pkg;

  // Fixed field widths
  localparam int IN_W      = 32;
  localparam int SEG_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_SEGS  = 5;

  // Level register reset values, truncated to the level width on use
  localparam int ATK_LVL_RST = 65535;
  localparam int SUS_LVL_RST = 32768;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAMES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_FRAMES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FRAMES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_FRAMES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_FRAMES = 3'd6;

  // Envelope segment codes
  typedef enum logic [SEG_W-1:0] {
    SEG_DELAY   = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4,
    SEG_END     = 3'd5
  } seg_e;

endpackage

`default_nettype wire

// ===== hdl/dadsr_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
`default_nettype none

module dadsr_div_pipe #(
  parameter int DEN_W = 24,
  parameter int Q_W   = 16,
  parameter int TAG_W = 20,
  localparam int NUM_W = DEN_W + Q_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [NUM_W-1:0] num_i,    // must stay below den_i * 2**Q_W
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [Q_W-1:0]        quot_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic             v_q   [Q_W];
  logic             en    [Q_W];
  logic [NUM_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] rem_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [NUM_W-1:0] trial;
    logic [NUM_W-1:0] rem_d;
    logic [Q_W-1:0]   quo_d;

    // Take the previous stage, or the input beat at the head
    if (j == 0) begin : g_head
      assign v_in   = in_valid_i;
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_body
      assign v_in   = v_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign tag_in = tag_q[j-1];
    end

    // Advance when this stage is empty or its successor moves
    if (j == Q_W - 1) begin : g_tail_en
      assign en[j] = !v_q[j] || out_ready_i;
    end else begin : g_mid_en
      assign en[j] = !v_q[j] || en[j+1];
    end

    // Try subtracting the shifted divisor for quotient bit Q_W-1-j
    always_comb begin
      trial = NUM_W'(den_in) << (Q_W - 1 - j);
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        quo_d[Q_W-1-j] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        den_q[j] <= den_in;
        tag_q[j] <= tag_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[Q_W-1];
  assign quot_o      = quo_q[Q_W-1];
  assign tag_o       = tag_q[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/delay_adsr_envelope_level_unit.sv =====
// Top level of the delay/ADSR linear envelope level unit.
//
// Usage: write the seven envelope registers through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while no beat is in flight. Each slave beat carries one absolute frame index;
// each master beat returns the envelope level at that frame in tdata and the
// segment code plus the finished flag in tuser.
// Throughput: one beat per clock while m_axis_tready is high. The pipeline has five segment-search stages,
// one ramp setup stage, one multiply stage, LEVEL_BITS divider stages (one
// quotient bit each) and an output register.
// Reset: all stage valid bits clear, frame lengths go to zero, attack level to
// all ones of the default 16-bit scale and sustain level to half scale.
// Stall: when m_axis_tready is low, results hold in place and each stage keeps
// accepting until its own successor is full; s_axis_tready drops only once the
// whole pipeline is occupied. Nothing is lost or repeated.
`default_nettype none

module delay_adsr_envelope_level_unit #(
  parameter int FRAME_BITS = 24,
  parameter int LEVEL_BITS = 16,
  localparam int CFG_W = (FRAME_BITS > LEVEL_BITS) ? FRAME_BITS : LEVEL_BITS,
  localparam int OUT_W = ((LEVEL_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dadsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]                   cfg_wdata_i,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [dadsr_pkg::IN_W-1:0]         s_axis_tdata,  // [31:0] frame_index
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [OUT_W-1:0]                        m_axis_tdata,  // [LEVEL_BITS-1:0] level
  output logic [dadsr_pkg::SEG_W:0]               m_axis_tuser   // [2:0] segment, [3] finished
);

  localparam int IN_W  = dadsr_pkg::IN_W;
  localparam int NSEG  = dadsr_pkg::NUM_SEGS;
  localparam int SEG_W = dadsr_pkg::SEG_W;
  localparam int PROD_W = FRAME_BITS + LEVEL_BITS;
  localparam int TAG_W  = LEVEL_BITS + 1 + SEG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [FRAME_BITS-1:0] delay_q, attack_q, decay_q, sustain_q, release_q;
  logic [LEVEL_BITS-1:0] atk_lvl_q, sus_lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= '0;
      attack_q  <= '0;
      decay_q   <= '0;
      sustain_q <= '0;
      release_q <= '0;
      atk_lvl_q <= LEVEL_BITS'(dadsr_pkg::ATK_LVL_RST);
      sus_lvl_q <= LEVEL_BITS'(dadsr_pkg::SUS_LVL_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dadsr_pkg::CFG_DELAY_FRAMES:   delay_q   <= cfg_wdata_i[FRAME_BITS-1:0];
        dadsr_pkg::CFG_ATTACK_FRAMES:  attack_q  <= cfg_wdata_i[FRAME_BITS-1:0];
        dadsr_pkg::CFG_ATTACK_LEVEL:   atk_lvl_q <= cfg_wdata_i[LEVEL_BITS-1:0];
        dadsr_pkg::CFG_DECAY_FRAMES:   decay_q   <= cfg_wdata_i[FRAME_BITS-1:0];
        dadsr_pkg::CFG_SUSTAIN_FRAMES: sustain_q <= cfg_wdata_i[FRAME_BITS-1:0];
        dadsr_pkg::CFG_SUSTAIN_LEVEL:  sus_lvl_q <= cfg_wdata_i[LEVEL_BITS-1:0];
        dadsr_pkg::CFG_RELEASE_FRAMES: release_q <= cfg_wdata_i[FRAME_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [FRAME_BITS-1:0] seg_len [NSEG];
  assign seg_len[0] = delay_q;
  assign seg_len[1] = attack_q;
  assign seg_len[2] = decay_q;
  assign seg_len[3] = sustain_q;
  assign seg_len[4] = release_q;

  // ---------------------------------------------------------------------------
  // Segment search: one segment compared per stage
  logic              fv_q   [NSEG];
  logic              fen    [NSEG];
  logic [IN_W-1:0]   ff_q   [NSEG];
  dadsr_pkg::seg_e   fseg_q [NSEG];
  logic              ffnd_q [NSEG];
  logic              sen;

  for (genvar k = 0; k < NSEG; k++) begin : g_find
    logic            v_in;
    logic [IN_W-1:0] f_in;
    dadsr_pkg::seg_e seg_in;
    logic            fnd_in;
    logic [IN_W-1:0] len_ext;
    logic [IN_W-1:0] f_d;
    dadsr_pkg::seg_e seg_d;
    logic            fnd_d;

    if (k == 0) begin : g_head
      assign v_in   = s_axis_tvalid;
      assign f_in   = s_axis_tdata;
      assign seg_in = dadsr_pkg::SEG_END;
      assign fnd_in = 1'b0;
    end else begin : g_body
      assign v_in   = fv_q[k-1];
      assign f_in   = ff_q[k-1];
      assign seg_in = fseg_q[k-1];
      assign fnd_in = ffnd_q[k-1];
    end

    if (k == NSEG - 1) begin : g_tail_en
      assign fen[k] = !fv_q[k] || sen;
    end else begin : g_mid_en
      assign fen[k] = !fv_q[k] || fen[k+1];
    end

    // Claim this segment, or step the offset past it
    always_comb begin
      len_ext = IN_W'(seg_len[k]);
      f_d     = f_in;
      seg_d   = seg_in;
      fnd_d   = fnd_in;
      if (!fnd_in) begin
        if (f_in < len_ext) begin
          seg_d = dadsr_pkg::seg_e'(k);
          fnd_d = 1'b1;
        end else begin
          f_d = f_in - len_ext;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[k] <= 1'b0;
      end else if (fen[k]) begin
        fv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (fen[k]) begin
        ff_q[k]   <= f_d;
        fseg_q[k] <= seg_d;
        ffnd_q[k] <= fnd_d;
      end
    end
  end

  assign s_axis_tready = fen[0];

  // ---------------------------------------------------------------------------
  // Ramp setup: pick end levels and length of the found segment
  logic                  sv_q;
  logic [FRAME_BITS-1:0] spos_q, slen_q;
  logic [LEVEL_BITS-1:0] sdiff_q, sfrom_q;
  logic                  sup_q;
  dadsr_pkg::seg_e       sseg_q;
  logic                  men;

  logic [LEVEL_BITS-1:0] lfrom, lto, ldiff;
  logic [FRAME_BITS-1:0] llen;
  logic                  lramp, lup;

  always_comb begin
    lfrom = '0;
    lto   = '0;
    llen  = '0;
    case (fseg_q[NSEG-1])
      dadsr_pkg::SEG_ATTACK: begin
        lto  = atk_lvl_q;
        llen = attack_q;
      end
      dadsr_pkg::SEG_DECAY: begin
        lfrom = atk_lvl_q;
        lto   = sus_lvl_q;
        llen  = decay_q;
      end
      dadsr_pkg::SEG_SUSTAIN: begin
        lfrom = sus_lvl_q;
        lto   = sus_lvl_q;
      end
      dadsr_pkg::SEG_RELEASE: begin
        lfrom = sus_lvl_q;
        llen  = release_q;
      end
      default: ;
    endcase
    lramp = fseg_q[NSEG-1] inside {dadsr_pkg::SEG_ATTACK, dadsr_pkg::SEG_DECAY,
                                   dadsr_pkg::SEG_RELEASE};
    lup   = (lto >= lfrom);
    ldiff = lup ? (lto - lfrom) : (lfrom - lto);
    // Flat segments divide zero by one so the divider sees a legal divisor
    if (!lramp) begin
      llen = FRAME_BITS'(1);
    end
  end

  assign sen = !sv_q || men;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else if (sen) begin
      sv_q <= fv_q[NSEG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sen) begin
      spos_q  <= ff_q[NSEG-1][FRAME_BITS-1:0];
      slen_q  <= llen;
      sdiff_q <= ldiff;
      sfrom_q <= lfrom;
      sup_q   <= lup;
      sseg_q  <= fseg_q[NSEG-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply: offset times height difference
  logic                  mv_q;
  logic [PROD_W-1:0]     mprod_q;
  logic [FRAME_BITS-1:0] mlen_q;
  logic [TAG_W-1:0]      mtag_q;
  logic                  div_in_ready;

  assign men = !mv_q || div_in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (men) begin
      mv_q <= sv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (men) begin
      mprod_q <= PROD_W'(spos_q) * PROD_W'(sdiff_q);
      mlen_q  <= slen_q;
      mtag_q  <= {sfrom_q, sup_q, sseg_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by segment length
  logic                  dv;
  logic [LEVEL_BITS-1:0] dquot;
  logic [TAG_W-1:0]      dtag;
  logic                  oen;

  dadsr_div_pipe #(
    .DEN_W (FRAME_BITS),
    .Q_W   (LEVEL_BITS),
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mv_q),
    .in_ready_o  (div_in_ready),
    .num_i       (mprod_q),
    .den_i       (mlen_q),
    .tag_i       (mtag_q),
    .out_valid_o (dv),
    .out_ready_i (oen),
    .quot_o      (dquot),
    .tag_o       (dtag)
  );

  // ---------------------------------------------------------------------------
  // Output register: apply the ramp term to the starting level
  logic                  ov_q;
  logic [LEVEL_BITS-1:0] olvl_q;
  logic [SEG_W-1:0]      oseg_q;
  logic [LEVEL_BITS-1:0] tfrom, olvl_d;
  logic                  tup;
  logic [SEG_W-1:0]      tseg;

  assign tfrom  = dtag[TAG_W-1 -: LEVEL_BITS];
  assign tup    = dtag[SEG_W];
  assign tseg   = dtag[SEG_W-1:0];
  assign olvl_d = tup ? (tfrom + dquot) : (tfrom - dquot);
  assign oen    = !ov_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (oen) begin
      ov_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oen) begin
      olvl_q <= olvl_d;
      oseg_q <= tseg;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_W'(olvl_q);
  assign m_axis_tuser  = {(oseg_q == dadsr_pkg::SEG_END), oseg_q};

endmodule

`default_nettype wire

// ===== hdl/dadsr_checker.sv =====
// Port-level assertions for the envelope level unit and the bind that attaches them.
`default_nettype none

module dadsr_checker #(
  parameter int FRAME_BITS = 24,
  parameter int LEVEL_BITS = 16,
  localparam int OUT_W = ((LEVEL_BITS + 7) / 8) * 8
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [OUT_W-1:0]                m_axis_tdata,
  input wire logic [dadsr_pkg::SEG_W:0]       m_axis_tuser
);

  localparam int SEG_W = dadsr_pkg::SEG_W;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Finished flag marks exactly the past-end segment
  a_fin_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[SEG_W] == (m_axis_tuser[SEG_W-1:0] == dadsr_pkg::SEG_END)))
    else $error("finished flag disagrees with segment");

  // Silent segments carry zero level
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[SEG_W-1:0] == dadsr_pkg::SEG_DELAY ||
                      m_axis_tuser[SEG_W-1:0] == dadsr_pkg::SEG_END) |->
      (m_axis_tdata == '0))
    else $error("nonzero level in delay or past end");

  // An empty output stage never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk_i)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

endmodule

bind delay_adsr_envelope_level_unit dadsr_checker #(
  .FRAME_BITS (FRAME_BITS),
  .LEVEL_BITS (LEVEL_BITS)
) u_dadsr_checker (.*);

`default_nettype wire
